>>> rtl/cgps_pkg.sv
package cgps_pkg;

   localparam int unsigned W = 48;
   localparam int unsigned QW = 64;
   localparam int unsigned SQW = 49;
   localparam int unsigned FRAC_BITS = 32;

   typedef enum logic [1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_PULL_GAIN = 2'd2,
      CSR_MIN_DISTANCE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [W-1:0] pos_x;
      logic signed [W-1:0] pos_y;
      logic signed [W-1:0] vel_x;
      logic signed [W-1:0] vel_y;
   } req_data_type;

   typedef struct packed {
      logic signed [W-1:0] new_pos_x;
      logic signed [W-1:0] new_pos_y;
      logic signed [W-1:0] new_vel_x;
      logic signed [W-1:0] new_vel_y;
      logic                distance_clamped;
   } rsp_data_type;

   // per-item context carried down the pipeline
   typedef struct packed {
      logic signed [W-1:0] pos_x;
      logic signed [W-1:0] pos_y;
      logic signed [W-1:0] vel_x;
      logic signed [W-1:0] vel_y;
      logic signed [W:0]   dx;
      logic signed [W:0]   dy;
   } ctx_type;

   localparam logic signed [W-1:0] MAX48 = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MIN48 = {1'b1, {(W-1){1'b0}}};

   function automatic logic signed [W-1:0] sat48(input logic signed [W+1:0] v);
      logic signed [W-1:0] r;
      begin
         if (v > $signed({{2{MAX48[W-1]}}, MAX48})) r = MAX48;
         else if (v < $signed({{2{MIN48[W-1]}}, MIN48})) r = MIN48;
         else r = v[W-1:0];
         return r;
      end
   endfunction

endpackage

>>> rtl/central_gravity_particle_step_unit.sv
// From accepted start to rsp_valid the pipeline has four front stages, 49 square
// root stages, the clamp, 3*64 divider stages and six back stages.
// Throughput: one transaction per clock; the square root and the three
// dividers are fully pipelined, one bit per stage.
// The receiver cannot stall; results appear for one cycle on rsp_valid.
// Reset (synchronous, active high) clears valid bits, loads center 600, gain 333.5, min 5.
module central_gravity_particle_step_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  cgps_pkg::req_data_type  req_data,
   output logic                    rsp_valid,
   output cgps_pkg::rsp_data_type  rsp_data,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [47:0]             csr_wdata
);
   import cgps_pkg::*;

   localparam int SB = SQW;          // sqrt result bits
   localparam int DB = QW;           // quotient bits per divide
   localparam int ND = 3;
   localparam int NS = 4 + SB + 1 + ND*DB + 6;

   logic signed [W-1:0] cx_ff, cy_ff;
   logic [W-1:0]        gain_ff;
   logic [W-2:0]        mind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff   <= 48'sd2576980377600;
         cy_ff   <= 48'sd2576980377600;
         gain_ff <= 48'd1432371593216;
         mind_ff <= 47'd21474836480;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTER_X:     cx_ff <= csr_wdata;
            CSR_CENTER_Y:     cy_ff <= csr_wdata;
            CSR_PULL_GAIN:    gain_ff <= csr_wdata;
            CSR_MIN_DISTANCE: mind_ff <= csr_wdata[W-2:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;
   logic acc;
   assign acc = start & ~busy;

   // ---------------- stage A: offsets ----------------
   logic    a_v_ff;
   ctx_type a_ctx_ff;
   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else a_v_ff <= acc;
      a_ctx_ff.pos_x <= req_data.pos_x;
      a_ctx_ff.pos_y <= req_data.pos_y;
      a_ctx_ff.vel_x <= req_data.vel_x;
      a_ctx_ff.vel_y <= req_data.vel_y;
      a_ctx_ff.dx <= {cx_ff[W-1], cx_ff} - {req_data.pos_x[W-1], req_data.pos_x};
      a_ctx_ff.dy <= {cy_ff[W-1], cy_ff} - {req_data.pos_y[W-1], req_data.pos_y};
   end

   // ---------------- stage B: abs ----------------
   logic b_v_ff;
   ctx_type b_ctx_ff;
   logic [W:0] b_ax_ff, b_ay_ff;
   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else b_v_ff <= a_v_ff;
      b_ctx_ff <= a_ctx_ff;
      b_ax_ff <= a_ctx_ff.dx[W] ? -a_ctx_ff.dx : a_ctx_ff.dx;
      b_ay_ff <= a_ctx_ff.dy[W] ? -a_ctx_ff.dy : a_ctx_ff.dy;
   end

   // ---------------- stage C: squares (split into 49x25 and 49x24 products) --------
   logic c_v_ff;
   ctx_type c_ctx_ff;
   logic [73:0] c_xl_ff, c_xh_ff, c_yl_ff, c_yh_ff;
   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else c_v_ff <= b_v_ff;
      c_ctx_ff <= b_ctx_ff;
      c_xl_ff <= 74'(b_ax_ff) * 74'(b_ax_ff[24:0]);
      c_xh_ff <= 74'(b_ax_ff) * 74'(b_ax_ff[W:25]);
      c_yl_ff <= 74'(b_ay_ff) * 74'(b_ay_ff[24:0]);
      c_yh_ff <= 74'(b_ay_ff) * 74'(b_ay_ff[W:25]);
   end

   // ---------------- stage D: sum of squares ----------------
   logic d_v_ff;
   ctx_type d_ctx_ff;
   logic [99:0] d_s_ff;
   always_ff @(posedge clock) begin
      if (reset) d_v_ff <= 1'b0;
      else d_v_ff <= c_v_ff;
      d_ctx_ff <= c_ctx_ff;
      d_s_ff <= 100'(c_xl_ff) + (100'(c_xh_ff) << 25)
              + 100'(c_yl_ff) + (100'(c_yh_ff) << 25);
   end

   // ---------------- square root, one bit per stage ----------------
   // trial root squared is built from the running square of the root
   logic    sq_v_ff   [SB+1];
   ctx_type sq_ctx_ff [SB+1];
   logic [99:0]   sq_s_ff [SB+1];
   logic [SB-1:0] sq_r_ff [SB+1];
   logic [99:0]   sq_rr_ff [SB+1];
   assign sq_v_ff[0] = d_v_ff;
   assign sq_ctx_ff[0] = d_ctx_ff;
   assign sq_s_ff[0] = d_s_ff;
   assign sq_r_ff[0] = '0;
   assign sq_rr_ff[0] = '0;

   for (genvar k = 0; k < SB; k++) begin : g_sqrt
      localparam int BIT = SB - 1 - k;
      logic [SB-1:0] t;
      logic [99:0] tt;
      assign t = sq_r_ff[k] | (SB'(1) << BIT);
      // (r + 2^BIT)^2, bits of r below BIT are still zero
      assign tt = sq_rr_ff[k] + (100'(sq_r_ff[k]) << (BIT + 1)) + (100'(1) << (2 * BIT));
      always_ff @(posedge clock) begin
         if (reset) sq_v_ff[k+1] <= 1'b0;
         else sq_v_ff[k+1] <= sq_v_ff[k];
         sq_ctx_ff[k+1] <= sq_ctx_ff[k];
         sq_s_ff[k+1] <= sq_s_ff[k];
         sq_r_ff[k+1] <= (tt <= sq_s_ff[k]) ? t : sq_r_ff[k];
         sq_rr_ff[k+1] <= (tt <= sq_s_ff[k]) ? tt : sq_rr_ff[k];
      end
   end

   // ---------------- clamp ----------------
   logic e_v_ff, e_cl_ff;
   ctx_type e_ctx_ff;
   logic [QW-1:0] e_d_ff;
   always_ff @(posedge clock) begin
      if (reset) e_v_ff <= 1'b0;
      else e_v_ff <= sq_v_ff[SB];
      e_ctx_ff <= sq_ctx_ff[SB];
      if (QW'(sq_r_ff[SB]) < QW'(mind_ff)) begin
         e_d_ff <= QW'(mind_ff);
         e_cl_ff <= 1'b1;
      end else begin
         e_d_ff <= QW'(sq_r_ff[SB]);
         e_cl_ff <= 1'b0;
      end
   end

   // ---------------- three dividers, one quotient bit per stage --------
   // numerator = prev << FRAC_BITS; saturate when high part >= d
   localparam int NST = ND*DB;
   logic          dv_v_ff   [NST+1];
   ctx_type       dv_ctx_ff [NST+1];
   logic          dv_cl_ff  [NST+1];
   logic [QW-1:0] dv_d_ff   [NST+1];
   logic [QW-1:0] dv_r_ff   [NST+1];
   logic [QW-1:0] dv_lo_ff  [NST+1];
   logic [QW-1:0] dv_q_ff   [NST+1];
   logic          dv_sat_ff [NST+1];

   logic [2*QW-1:0] n0;
   assign n0 = (2*QW)'(gain_ff) << FRAC_BITS;
   assign dv_v_ff[0] = e_v_ff;
   assign dv_ctx_ff[0] = e_ctx_ff;
   assign dv_cl_ff[0] = e_cl_ff;
   assign dv_d_ff[0] = e_d_ff;
   assign dv_r_ff[0] = n0[2*QW-1:QW];
   assign dv_lo_ff[0] = n0[QW-1:0];
   assign dv_q_ff[0] = '0;
   assign dv_sat_ff[0] = (e_d_ff == '0) || (n0[2*QW-1:QW] >= e_d_ff);

   for (genvar k = 0; k < NST; k++) begin : g_div
      localparam int IB = DB - 1 - (k % DB);
      localparam bit LAST = ((k % DB) == DB - 1);
      localparam bit FINAL = (k == NST - 1);
      logic          carry, take;
      logic [QW-1:0] r1, r2, q1, qf;
      logic [2*QW-1:0] nn;
      always_comb begin
         carry = dv_r_ff[k][QW-1];
         r1 = {dv_r_ff[k][QW-2:0], dv_lo_ff[k][IB]};
         take = carry || (r1 >= dv_d_ff[k]);
         r2 = take ? r1 - dv_d_ff[k] : r1;
         q1 = {dv_q_ff[k][QW-2:0], take};
         // zero distance gives zero, saturation gives all ones
         if (dv_d_ff[k] == '0) qf = '0;
         else if (dv_sat_ff[k]) qf = '1;
         else qf = q1;
         nn = (2*QW)'(qf) << FRAC_BITS;
      end
      always_ff @(posedge clock) begin
         if (reset) dv_v_ff[k+1] <= 1'b0;
         else dv_v_ff[k+1] <= dv_v_ff[k];
         dv_ctx_ff[k+1] <= dv_ctx_ff[k];
         dv_cl_ff[k+1] <= dv_cl_ff[k];
         dv_d_ff[k+1] <= dv_d_ff[k];
         if (LAST && !FINAL) begin
            dv_r_ff[k+1] <= nn[2*QW-1:QW];
            dv_lo_ff[k+1] <= nn[QW-1:0];
            dv_q_ff[k+1] <= '0;
            dv_sat_ff[k+1] <= (dv_d_ff[k] == '0) || (nn[2*QW-1:QW] >= dv_d_ff[k]);
         end else if (LAST) begin
            dv_r_ff[k+1] <= r2;
            dv_lo_ff[k+1] <= dv_lo_ff[k];
            dv_q_ff[k+1] <= qf;
            dv_sat_ff[k+1] <= 1'b0;
         end else begin
            dv_r_ff[k+1] <= r2;
            dv_lo_ff[k+1] <= dv_lo_ff[k];
            dv_q_ff[k+1] <= q1;
            dv_sat_ff[k+1] <= dv_sat_ff[k];
         end
      end
   end

   // ---------------- increment: g3 * |off| in 32-bit pieces ----------
   logic f_v_ff, f_cl_ff;
   ctx_type f_ctx_ff;
   logic [W:0] f_ax_ff, f_ay_ff;
   logic [QW-1:0] f_g_ff;
   always_ff @(posedge clock) begin
      if (reset) f_v_ff <= 1'b0;
      else f_v_ff <= dv_v_ff[NST];
      f_ctx_ff <= dv_ctx_ff[NST];
      f_cl_ff <= dv_cl_ff[NST];
      f_g_ff <= dv_q_ff[NST];
      f_ax_ff <= dv_ctx_ff[NST].dx[W] ? -dv_ctx_ff[NST].dx : dv_ctx_ff[NST].dx;
      f_ay_ff <= dv_ctx_ff[NST].dy[W] ? -dv_ctx_ff[NST].dy : dv_ctx_ff[NST].dy;
   end

   // partial products: g split 32/32, |off| split 25/24
   logic g_v_ff, g_cl_ff;
   ctx_type g_ctx_ff;
   logic [56:0] g_px_ff [4];
   logic [56:0] g_py_ff [4];
   always_ff @(posedge clock) begin
      if (reset) g_v_ff <= 1'b0;
      else g_v_ff <= f_v_ff;
      g_ctx_ff <= f_ctx_ff;
      g_cl_ff <= f_cl_ff;
      g_px_ff[0] <= 57'(f_g_ff[31:0]) * 57'(f_ax_ff[24:0]);
      g_px_ff[1] <= 57'(f_g_ff[31:0]) * 57'(f_ax_ff[W:25]);
      g_px_ff[2] <= 57'(f_g_ff[63:32]) * 57'(f_ax_ff[24:0]);
      g_px_ff[3] <= 57'(f_g_ff[63:32]) * 57'(f_ax_ff[W:25]);
      g_py_ff[0] <= 57'(f_g_ff[31:0]) * 57'(f_ay_ff[24:0]);
      g_py_ff[1] <= 57'(f_g_ff[31:0]) * 57'(f_ay_ff[W:25]);
      g_py_ff[2] <= 57'(f_g_ff[63:32]) * 57'(f_ay_ff[24:0]);
      g_py_ff[3] <= 57'(f_g_ff[63:32]) * 57'(f_ay_ff[W:25]);
   end

   logic h_v_ff, h_cl_ff;
   ctx_type h_ctx_ff;
   logic [127:0] h_mx_ff, h_my_ff;
   always_ff @(posedge clock) begin
      if (reset) h_v_ff <= 1'b0;
      else h_v_ff <= g_v_ff;
      h_ctx_ff <= g_ctx_ff;
      h_cl_ff <= g_cl_ff;
      h_mx_ff <= 128'(g_px_ff[0]) + (128'(g_px_ff[1]) << 25)
               + (128'(g_px_ff[2]) << 32) + (128'(g_px_ff[3]) << 57);
      h_my_ff <= 128'(g_py_ff[0]) + (128'(g_py_ff[1]) << 25)
               + (128'(g_py_ff[2]) << 32) + (128'(g_py_ff[3]) << 57);
   end

   // scale, saturate, sign
   function automatic logic signed [W-1:0] incr(input logic [127:0] m, input logic neg);
      logic [127:0] s;
      logic signed [W-1:0] r;
      begin
         s = m >> FRAC_BITS;
         if (neg) r = (s >= 128'(64'h800000000000)) ? MIN48 : -$signed(s[W-1:0]);
         else r = (s > 128'(64'h7FFFFFFFFFFF)) ? MAX48 : $signed(s[W-1:0]);
         return r;
      end
   endfunction

   logic i_v_ff, i_cl_ff;
   ctx_type i_ctx_ff;
   logic signed [W-1:0] i_ix_ff, i_iy_ff;
   always_ff @(posedge clock) begin
      if (reset) i_v_ff <= 1'b0;
      else i_v_ff <= h_v_ff;
      i_ctx_ff <= h_ctx_ff;
      i_cl_ff <= h_cl_ff;
      i_ix_ff <= incr(h_mx_ff, h_ctx_ff.dx[W]);
      i_iy_ff <= incr(h_my_ff, h_ctx_ff.dy[W]);
   end

   logic j_v_ff, j_cl_ff;
   ctx_type j_ctx_ff;
   logic signed [W-1:0] j_vx_ff, j_vy_ff;
   always_ff @(posedge clock) begin
      if (reset) j_v_ff <= 1'b0;
      else j_v_ff <= i_v_ff;
      j_ctx_ff <= i_ctx_ff;
      j_cl_ff <= i_cl_ff;
      j_vx_ff <= sat48((W+2)'(i_ctx_ff.vel_x) + (W+2)'(i_ix_ff));
      j_vy_ff <= sat48((W+2)'(i_ctx_ff.vel_y) + (W+2)'(i_iy_ff));
   end

   logic k_v_ff;
   rsp_data_type k_rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) k_v_ff <= 1'b0;
      else k_v_ff <= j_v_ff;
      k_rsp_ff.new_pos_x <= sat48((W+2)'(j_ctx_ff.pos_x) + (W+2)'(j_vx_ff));
      k_rsp_ff.new_pos_y <= sat48((W+2)'(j_ctx_ff.pos_y) + (W+2)'(j_vy_ff));
      k_rsp_ff.new_vel_x <= j_vx_ff;
      k_rsp_ff.new_vel_y <= j_vy_ff;
      k_rsp_ff.distance_clamped <= j_cl_ff;
   end

   assign rsp_valid = k_v_ff;
   assign rsp_data = k_rsp_ff;

   logic unused_ok;
   assign unused_ok = ^{NS, f_ctx_ff.dx[0]};
endmodule

>>> rtl/cgps_checker.sv
module cgps_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input cgps_pkg::rsp_data_type rsp_data
);
   import cgps_pkg::*;

   localparam int LATENCY = 252;

   a_never_busy: assert property (@(posedge clock) busy == 1'b0)
      else $error("busy raised");
   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result right after reset");
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result missing after fixed latency");
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_data))
      else $error("result fields unknown");
endmodule

bind central_gravity_particle_step_unit cgps_checker u_cgps_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

>>> tb/central_gravity_particle_step_unit_test.sv
module central_gravity_particle_step_unit_test;
   import cgps_pkg::*;

   localparam logic signed [47:0] CENTER_600 = 48'sh0258_0000_0000;
   localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;
   localparam logic signed [47:0] ONE = 48'sh0001_0000_0000;
   localparam int N_RANDOM = 1600;

   typedef struct {
      logic signed [47:0] cx;
      logic signed [47:0] cy;
      logic [47:0]        gain;
      logic [46:0]        min_dist;
   } field_cfg_type;

   typedef struct {
      int           cfg;
      req_data_type req;
      bit           typed;
      rsp_data_type rsp;
   } stim_row_type;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   req_data_type  req_data;
   logic          rsp_valid;
   rsp_data_type  rsp_data;
   logic          csr_we;
   logic [1:0]    csr_index;
   logic [47:0]   csr_wdata;

   field_cfg_type cfg_sets[8];
   field_cfg_type field;
   stim_row_type  stim_rows[$];
   rsp_data_type  pending_steps[$];
   int            n_errors;
   int            n_results;
   int            n_clamped;
   int            n_sent;

   central_gravity_particle_step_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic signed [47:0] sat_q48(longint v);
      if (v > longint'(POS_MAX)) return POS_MAX;
      if (v < longint'(POS_MIN)) return POS_MIN;
      return v[47:0];
   endfunction

   // pull term g3*|off| >> 32, signed like the offset, saturated
   function automatic longint kick(logic [63:0] g3, longint off);
      logic [63:0]  mag;
      logic [127:0] prod;
      mag = off < 0 ? -off : off;
      prod = ({64'd0, g3} * {64'd0, mag}) >> 32;
      if (off < 0) return (prod >= 128'h8000_0000_0000) ? longint'(POS_MIN) : -longint'(prod);
      return (prod > 128'h7FFF_FFFF_FFFF) ? longint'(POS_MAX) : longint'(prod);
   endfunction

   function automatic rsp_data_type step_particle(req_data_type p);
      longint       dx, dy;
      logic [63:0]  ax, ay, d, g, r;
      logic [127:0] s, t, q;
      rsp_data_type o;
      dx = longint'(field.cx) - longint'(p.pos_x);
      dy = longint'(field.cy) - longint'(p.pos_y);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      s = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
      r = 0;
      for (int b = 48; b >= 0; b--) begin
         t = {64'd0, r | (64'd1 << b)};
         if (t * t <= s) r = t[63:0];
      end
      d = r;
      o.distance_clamped = 1'b0;
      if (d < {17'd0, field.min_dist}) begin
         d = {17'd0, field.min_dist};
         o.distance_clamped = 1'b1;
      end
      g = 0;
      if (d != 0) begin
         g = {16'd0, field.gain};
         repeat (3) begin
            q = ({64'd0, g} << 32) / {64'd0, d};
            g = (q > 128'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
         end
      end
      o.new_vel_x = sat_q48(longint'(p.vel_x) + kick(g, dx));
      o.new_vel_y = sat_q48(longint'(p.vel_y) + kick(g, dy));
      o.new_pos_x = sat_q48(longint'(p.pos_x) + longint'(o.new_vel_x));
      o.new_pos_y = sat_q48(longint'(p.pos_y) + longint'(o.new_vel_y));
      return o;
   endfunction

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   function automatic logic signed [47:0] near(logic signed [47:0] c);
      logic signed [47:0] off;
      case ($urandom_range(2))
         0: off = $signed(48'($urandom_range(32'h000F_FFFF))) - 48'sh8_0000;
         1: off = $signed({{8{1'b0}}, 40'($urandom)}) - 48'sh80_0000_0000;
         default: off = $signed({{12{1'b0}}, {4'($urandom), 32'($urandom)}})
                        - 48'sh8_0000_0000;
      endcase
      return c + off;
   endfunction

   task automatic write_reg(csr_index_type idx, logic [47:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // registers change only with the pipeline drained
   task automatic load_field(int k);
      start <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_reg(CSR_CENTER_X, cfg_sets[k].cx);
      write_reg(CSR_CENTER_Y, cfg_sets[k].cy);
      write_reg(CSR_PULL_GAIN, cfg_sets[k].gain);
      write_reg(CSR_MIN_DISTANCE, {1'b0, cfg_sets[k].min_dist});
      csr_we <= 1'b0;
      field = cfg_sets[k];
   endtask

   task automatic send_particle(req_data_type p, bit typed, rsp_data_type want);
      start <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (busy);
      pending_steps.push_back(typed ? want : step_particle(p));
      n_sent++;
   endtask

   function automatic req_data_type mk_req(logic signed [47:0] px, logic signed [47:0] py,
                                           logic signed [47:0] vx, logic signed [47:0] vy);
      req_data_type p;
      p.pos_x = px;
      p.pos_y = py;
      p.vel_x = vx;
      p.vel_y = vy;
      return p;
   endfunction

   function automatic rsp_data_type mk_rsp(logic signed [47:0] px, logic signed [47:0] py,
                                           logic signed [47:0] vx, logic signed [47:0] vy,
                                           logic cl);
      rsp_data_type o;
      o.new_pos_x = px;
      o.new_pos_y = py;
      o.new_vel_x = vx;
      o.new_vel_y = vy;
      o.distance_clamped = cl;
      return o;
   endfunction

   task automatic add_row(int k, req_data_type p, bit typed, rsp_data_type want);
      stim_row_type row;
      row.cfg = k;
      row.req = p;
      row.typed = typed;
      row.rsp = want;
      stim_rows.push_back(row);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_steps.size() == 0) begin
            $error("transaction with no expectation waiting");
            n_errors++;
         end else begin
            rsp_data_type e;
            e = pending_steps.pop_front();
            n_results++;
            if (rsp_data.distance_clamped) n_clamped++;
            if (rsp_data.new_pos_x !== e.new_pos_x) begin
               $error("new_pos_x exp %h got %h", e.new_pos_x, rsp_data.new_pos_x);
               n_errors++;
            end
            if (rsp_data.new_pos_y !== e.new_pos_y) begin
               $error("new_pos_y exp %h got %h", e.new_pos_y, rsp_data.new_pos_y);
               n_errors++;
            end
            if (rsp_data.new_vel_x !== e.new_vel_x) begin
               $error("new_vel_x exp %h got %h", e.new_vel_x, rsp_data.new_vel_x);
               n_errors++;
            end
            if (rsp_data.new_vel_y !== e.new_vel_y) begin
               $error("new_vel_y exp %h got %h", e.new_vel_y, rsp_data.new_vel_y);
               n_errors++;
            end
            if (rsp_data.distance_clamped !== e.distance_clamped) begin
               $error("distance_clamped exp %b got %b", e.distance_clamped,
                      rsp_data.distance_clamped);
               n_errors++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("timeout with %0d transactions outstanding", pending_steps.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      rsp_data_type none;
      int k;
      none = '0;
      n_errors = 0;
      n_results = 0;
      n_clamped = 0;
      n_sent = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_CENTER_X;
      csr_wdata = '0;

      cfg_sets[0] = '{CENTER_600, CENTER_600, 48'h014D_8000_0000, 47'h5_0000_0000};
      cfg_sets[1] = '{CENTER_600, CENTER_600, 48'h014D_8000_0000, 47'd0};
      cfg_sets[2] = '{CENTER_600, -CENTER_600, 48'hFFFF_FFFF_FFFF, 47'd0};
      cfg_sets[3] = '{-CENTER_600, 48'sd0, 48'd0, 47'h5_0000_0000};
      cfg_sets[4] = '{POS_MAX, POS_MIN, 48'h0001_0000_0000, 47'h7FFF_FFFF_FFFF};
      cfg_sets[5] = '{POS_MIN, POS_MAX, 48'h7FFF_0000_0000, 47'h1_0000_0000};
      cfg_sets[6] = '{48'sh10_0000_0000, 48'sh20_0000_0000, 48'h00FF_1234_5678,
                      47'h0_8000_0000};
      cfg_sets[7] = '{-48'sh3_0000_0000, CENTER_600, 48'h0010_0000_0000, 47'h2_0000_0000};
      field = cfg_sets[0];

      add_row(0, mk_req(CENTER_600, CENTER_600, 0, 0), 1,
              mk_rsp(CENTER_600, CENTER_600, 0, 0, 1'b1));
      add_row(0, mk_req(POS_MAX, POS_MAX, POS_MAX, POS_MAX), 0, none);
      add_row(0, mk_req(POS_MIN, POS_MIN, POS_MIN, POS_MIN), 0, none);
      add_row(0, mk_req(POS_MIN, POS_MAX, POS_MAX, POS_MIN), 0, none);
      add_row(0, mk_req(0, 0, 0, 0), 0, none);
      add_row(0, mk_req(CENTER_600 + 3 * ONE, CENTER_600, 0, ONE), 0, none);
      add_row(0, mk_req(CENTER_600 - 100 * ONE, CENTER_600 + 7, -ONE, 0), 0, none);
      add_row(0, mk_req(CENTER_600 + 4 * ONE, CENTER_600 - 3 * ONE, 0, 0), 0, none);
      // zero distance: no pull at all
      add_row(1, mk_req(CENTER_600, CENTER_600, 5, -7), 1,
              mk_rsp(CENTER_600 + 5, CENTER_600 - 7, 5, -7, 1'b0));
      add_row(1, mk_req(CENTER_600, CENTER_600, POS_MAX, POS_MIN), 1,
              mk_rsp(POS_MAX, CENTER_600 + POS_MIN, POS_MAX, POS_MIN, 1'b0));
      add_row(1, mk_req(CENTER_600 + 1, CENTER_600, 0, 0), 0, none);
      // huge pull saturates the kick
      add_row(2, mk_req(CENTER_600 + 1, -CENTER_600, 0, 0), 0, none);
      add_row(2, mk_req(CENTER_600 - 1, -CENTER_600 + 1, 0, 0), 0, none);
      add_row(2, mk_req(CENTER_600, -CENTER_600 - ONE, POS_MAX, 0), 0, none);
      add_row(3, mk_req(POS_MAX, POS_MIN, 1, -1), 0, none);
      add_row(4, mk_req(0, 0, POS_MAX, POS_MIN), 0, none);
      add_row(5, mk_req(POS_MAX, POS_MIN, 0, 0), 0, none);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      k = -1;
      foreach (stim_rows[i]) begin
         if (stim_rows[i].cfg != k) begin
            k = stim_rows[i].cfg;
            load_field(k);
         end
         send_particle(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].rsp);
      end

      for (int ph = 0; ph < 8; ph++) begin
         load_field((ph + 3) % 8);
         for (int n = 0; n < N_RANDOM / 8; n++) begin
            req_data_type p;
            // phase 2 runs back to back
            if (ph != 2 && $urandom_range(99) < 10) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 4)) @(posedge clock);
            end
            if ($urandom_range(3) != 0)
               p = mk_req(near(field.cx), near(field.cy),
                          $urandom_range(1) ? near(0) : rand48(), near(0));
            else
               p = mk_req(rand48(), rand48(), rand48(), rand48());
            send_particle(p, 0, none);
         end
      end
      start <= 1'b0;

      while (pending_steps.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      $display("%0d particles stepped over 8 register settings, %0d results checked,",
               n_sent, n_results);
      $display("%0d with distance clamped, %0d mismatches", n_clamped, n_errors);
      if (n_errors == 0 && pending_steps.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
